// ===== rtl/core/pli_pkg.sv =====
// Shared types and constants for the positional insert list.
`timescale 1ns / 1ps

package pli_pkg;

    // Fixed widths of the word fields.
    localparam int RANK_W  = 11;
    localparam int ELEM_FW = 16;

    // Item kinds.
    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_LOOKUP = 1'b1;

    typedef struct packed {
        logic              kind;
        logic [RANK_W-1:0]  rank;
        logic [ELEM_FW-1:0] pair_first;
        logic [ELEM_FW-1:0] pair_second;
    } pli_req_t;

    typedef struct packed {
        logic [ELEM_FW-1:0] out_first;
        logic [ELEM_FW-1:0] out_second;
        logic               found;
        logic               full_drop;
        logic [RANK_W-1:0]  entry_count;
    } pli_rsp_t;

    // Broadcast controls from the sequencer to every cell.
    typedef struct packed {
        logic ins;       // insert at broadcast position this cycle
        logic rd_load;   // copy all entries into the read chain
        logic rd_shift;  // move the read chain one cell toward cell 0
    } pli_ctl_t;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } pli_state_t;

endpackage

// ===== rtl/core/pli_cell.sv =====
// One list cell: a stored pair plus one stage of the read chain.
`timescale 1ns / 1ps

module pli_cell
    import pli_pkg::*;
#(
    parameter int IDX = 0,
    parameter int PW  = 11,
    parameter int SW  = 16
) (
    input  logic            clk,
    input  pli_ctl_t        ctl,
    input  logic [PW-1:0]   pos,
    input  logic [2*SW-1:0] new_entry,
    input  logic [2*SW-1:0] prev_entry,
    input  logic [2*SW-1:0] rd_in,
    output logic [2*SW-1:0] entry,
    output logic [2*SW-1:0] rd
);

    localparam logic [PW-1:0] MY_IDX = PW'(IDX);

    logic [2*SW-1:0] entry_reg;
    logic [2*SW-1:0] entry_next;
    logic [2*SW-1:0] rd_reg;
    logic [2*SW-1:0] rd_next;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.ins)
        begin
            if (MY_IDX == pos)
            begin
                entry_next = new_entry;
            end
            else if (MY_IDX > pos)
            begin
                entry_next = prev_entry;   // make room: take lower neighbor
            end
        end

        rd_next = rd_reg;
        if (ctl.rd_load)
        begin
            rd_next = entry_reg;
        end
        else if (ctl.rd_shift)
        begin
            rd_next = rd_in;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        rd_reg    <= rd_next;
    end

    assign entry = entry_reg;
    assign rd    = rd_reg;

endmodule

// ===== rtl/core/positional_insert_list_unit.sv =====
// Top level of the positional insert list: cell row, sequencer and response register.
`timescale 1ns / 1ps

// Bounded ordered list of value pairs addressed by zero-based rank. An insert
// word places a pair at its rank, moving every entry at or above that rank up
// one place at once; a rank beyond the current count appends, and an insert
// into a full list (CAPACITY entries) leaves the list alone and returns
// full_drop. A lookup word returns the pair at its rank with found set, or
// zeros with found clear when the rank is at or above the count. Every word
// gives exactly one response word, which carries the entry count after it.
// Timing: inserts and out-of-range lookups are answered straight from the idle
// state and leave it idle for the next word. A lookup at rank r copies the
// whole row into a read chain that moves one cell per cycle toward cell 0
// until entry r reaches cell 0, so the chain length up to it sets the latency. New
// words are taken only while no lookup is in flight and the response register
// is free or being drained. Storage holds no reset value; no clearing pass is
// needed since only written entries are ever read.
module positional_insert_list_unit
    import pli_pkg::*;
#(
    parameter int CAPACITY   = 1024,
    parameter int ELEM_WIDTH = 16
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_ready,
    input  pli_req_t req,
    output logic     rsp_valid,
    input  logic     rsp_ready,
    output pli_rsp_t rsp
);

    // PW holds a count 0..CAPACITY, IW an index 0..CAPACITY-1.
    localparam int PW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);
    localparam int WW = (PW > RANK_W) ? PW : RANK_W;
    localparam int SW = (ELEM_WIDTH < ELEM_FW) ? ELEM_WIDTH : ELEM_FW;
    localparam logic [PW-1:0] CAP_COUNT = PW'(CAPACITY);

    pli_state_t     state_reg;
    pli_state_t     state_next;
    logic [IW-1:0]  scan_cnt_reg;
    logic [IW-1:0]  scan_cnt_next;
    logic [PW-1:0]  count_reg;
    logic [PW-1:0]  count_next;
    pli_rsp_t       rsp_reg;
    pli_rsp_t       rsp_next;
    logic           rsp_valid_reg;
    logic           rsp_valid_next;

    pli_ctl_t        ctl;
    logic [PW-1:0]   pos;
    logic [2*SW-1:0] new_entry;
    logic [WW-1:0]   rank_w;
    logic [WW-1:0]   count_w;
    logic            is_full;
    logic            in_range;
    logic            accept;

    logic [2*SW-1:0] entry_w [CAPACITY];
    logic [2*SW-1:0] rd_w    [CAPACITY];

    // ---------------------------------------------------------------
    // Rank decode
    // ---------------------------------------------------------------
    assign rank_w    = WW'(req.rank);
    assign count_w   = WW'(count_reg);
    assign is_full   = (count_reg == CAP_COUNT);
    assign in_range  = (rank_w < count_w);
    // Clamp to count so a rank past the end appends.
    assign pos       = (rank_w > count_w) ? count_reg : PW'(rank_w);
    assign new_entry = {SW'(req.pair_first), SW'(req.pair_second)};

    assign req_ready = (state_reg == ST_IDLE) && (!rsp_valid_reg || rsp_ready);
    assign accept    = req_valid && req_ready;

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        scan_cnt_next  = scan_cnt_reg;
        count_next     = count_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        ctl            = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (req.kind == KIND_INSERT)
                    begin
                        rsp_next       = '0;
                        rsp_valid_next = 1'b1;
                        if (is_full)
                        begin
                            rsp_next.full_drop = 1'b1;
                        end
                        else
                        begin
                            ctl.ins    = 1'b1;
                            count_next = count_reg + 1'b1;
                        end
                        rsp_next.entry_count = RANK_W'(count_next);
                    end
                    else if (in_range)
                    begin
                        // Snapshot the row, then walk it down to cell 0.
                        ctl.rd_load   = 1'b1;
                        scan_cnt_next = IW'(rank_w);
                        state_next    = ST_SCAN;
                    end
                    else
                    begin
                        rsp_next             = '0;
                        rsp_next.entry_count = RANK_W'(count_reg);
                        rsp_valid_next       = 1'b1;
                    end
                end
            end

            ST_SCAN:
            begin
                if (scan_cnt_reg == '0)
                begin
                    rsp_next.out_first   = ELEM_FW'(rd_w[0][2*SW-1:SW]);
                    rsp_next.out_second  = ELEM_FW'(rd_w[0][SW-1:0]);
                    rsp_next.found       = 1'b1;
                    rsp_next.full_drop   = 1'b0;
                    rsp_next.entry_count = RANK_W'(count_reg);
                    rsp_valid_next       = 1'b1;
                    state_next           = ST_IDLE;
                end
                else
                begin
                    ctl.rd_shift  = 1'b1;
                    scan_cnt_next = scan_cnt_reg - 1'b1;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            scan_cnt_reg  <= '0;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            scan_cnt_reg  <= scan_cnt_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // ---------------------------------------------------------------
    // Cell row: inserts ripple upward, reads ripple toward cell 0
    // ---------------------------------------------------------------
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [2*SW-1:0] prev_entry;
        logic [2*SW-1:0] rd_in;

        if (i == 0)
        begin : g_first
            assign prev_entry = '0;
        end
        else
        begin : g_mid
            assign prev_entry = entry_w[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign rd_in = '0;
        end
        else
        begin : g_body
            assign rd_in = rd_w[i+1];
        end

        pli_cell #(
            .IDX (i),
            .PW  (PW),
            .SW  (SW)
        ) u_cell (
            .clk        (clk),
            .ctl        (ctl),
            .pos        (pos),
            .new_entry  (new_entry),
            .prev_entry (prev_entry),
            .rd_in      (rd_in),
            .entry      (entry_w[i]),
            .rd         (rd_w[i])
        );
    end

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP_COUNT)
        else $error("entry count above capacity");

    a_slot_free_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> !rsp_valid_reg)
        else $error("response register busy during lookup walk");

    a_insert_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req.kind == KIND_INSERT && !is_full)
            |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("insert did not advance entry count");

    a_scan_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && scan_cnt_reg == '0)
            |=> (rsp_valid_reg && rsp_reg.found && state_reg == ST_IDLE))
        else $error("lookup walk ended without a found response");

endmodule

// ===== bench/tb_positional_insert_list_unit.sv =====
// Self-checking testbench for the positional insert list unit.
`timescale 1ns / 1ps

// Drives insert and lookup words into the list through a valid/ready port and
// checks every response word against a rank-addressed list kept inside the
// bench. Stimulus runs in three parts:
// - a short directed part that covers empty-list lookups, front, middle and
//   append inserts, and ranks past the end;
// - a random mix that grows the list;
// - a fill to full capacity, which is followed by dropped inserts and by
//   lookups at the far end.
// The sender works in random bursts. The receiver stalls in changing patterns
// and, once, holds off long enough to back the block up.
module tb_positional_insert_list_unit;
    import pli_pkg::*;

    localparam int CAP         = 1024;
    localparam int LIW         = $clog2(CAP);
    localparam int MAX_RANK    = (1 << RANK_W) - 1;
    localparam int RANDOM_WORDS = 200;
    // Worst legal quiet stretch: lookup at the last rank plus
    // the long receiver hold-off. Several times over.
    localparam int QUIET_LIMIT = 20000;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES = 64;

    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     req_valid = 1'b0;
    logic     req_ready;
    pli_req_t req       = '0;
    logic     rsp_valid;
    logic     rsp_ready = 1'b0;
    pli_rsp_t rsp;

    positional_insert_list_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always #1 clk = ~clk;

    // Words waiting to be sent, and responses owed by the block, oldest first.
    pli_req_t pending_words[$];
    pli_rsp_t owed_rsps[$];

    // Bench copy of the list contents.
    logic [ELEM_FW-1:0] list_first[CAP];
    logic [ELEM_FW-1:0] list_second[CAP];
    int                 list_len = 0;

    // Length the list will have once every queued word is applied; used to
    // steer ranks while the stimulus is planned.
    int plan_len = 0;

    int   fail_count = 0;
    int   rsp_seen   = 0;
    logic req_took   = 1'b0;

    // Apply one accepted word to the bench list and return the response it owes.
    function automatic pli_rsp_t list_step(pli_req_t w);
        pli_rsp_t r;
        int       pos;
        int       i;
        r = '0;
        if (w.kind == KIND_INSERT) begin
            if (list_len >= CAP) begin
                r.full_drop = 1'b1;
            end
            else begin
                // ranks past the end append
                pos = (int'(w.rank) > list_len) ? list_len : int'(w.rank);
                for (i = list_len; i > pos; i--)
                begin
                    list_first[i]  = list_first[i-1];
                    list_second[i] = list_second[i-1];
                end
                list_first[pos]  = w.pair_first;
                list_second[pos] = w.pair_second;
                list_len++;
            end
        end
        else if (int'(w.rank) < list_len) begin
            r.out_first  = list_first[w.rank[LIW-1:0]];
            r.out_second = list_second[w.rank[LIW-1:0]];
            r.found      = 1'b1;
        end
        r.entry_count = RANK_W'(list_len);
        return r;
    endfunction

    task automatic queue_insert(int r, logic [ELEM_FW-1:0] a, logic [ELEM_FW-1:0] b);
        pli_req_t w;
        w.kind        = KIND_INSERT;
        w.rank        = RANK_W'(r);
        w.pair_first  = a;
        w.pair_second = b;
        pending_words = {pending_words, w};
        if (plan_len < CAP)
            plan_len++;
    endtask

    // Pair fields of a lookup carry junk; the block must ignore them.
    task automatic queue_lookup(int r);
        pli_req_t w;
        w.kind        = KIND_LOOKUP;
        w.rank        = RANK_W'(r);
        w.pair_first  = ELEM_FW'($urandom);
        w.pair_second = ELEM_FW'($urandom);
        pending_words = {pending_words, w};
    endtask

    task automatic check_field(string field, int unsigned want_v, int unsigned got_v);
        if (want_v != got_v) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h",
                     $time, field, want_v, got_v);
            fail_count++;
        end
    endtask

    // ---------------------------------------------------------------
    // Sender: bursts of random length with random gaps in between.
    // Each output gets a single nonblocking write per falling edge.
    // ---------------------------------------------------------------
    int burst_left = 1;
    int gap_left   = 0;

    always @(negedge clk) begin
        if (rst_n && (!req_valid || req_took)) begin
            if (gap_left > 0) begin
                gap_left--;
                req_valid <= 1'b0;
            end
            else if (pending_words.size() != 0) begin
                req       <= pending_words.pop_front();
                req_valid <= 1'b1;
                burst_left--;
                if (burst_left <= 0) begin
                    // now and then a long burst with no idling at all
                    burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 250)
                                                             : $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
            else begin
                req_valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // Receiver: stall pattern switches every so often; one long
    // hold-off after a few dozen responses so the block backs up.
    // ---------------------------------------------------------------
    int   ready_mode = 0;
    int   mode_left  = 50;
    int   hold_left  = 0;
    int   phase_cnt  = 0;
    logic hold_done  = 1'b0;

    always @(negedge clk) begin
        if (rst_n) begin
            phase_cnt++;
            if (hold_left > 0) begin
                hold_left--;
                rsp_ready <= 1'b0;
            end
            else if (!hold_done && rsp_seen >= 60) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                rsp_ready <= 1'b0;
            end
            else begin
                if (mode_left == 0) begin
                    ready_mode = $urandom_range(0, 3);
                    mode_left  = $urandom_range(20, 200);
                end
                mode_left--;
                case (ready_mode)
                    0:       rsp_ready <= 1'b1;
                    1:       rsp_ready <= 1'($urandom_range(0, 1));
                    2:       rsp_ready <= (phase_cnt % 4 == 0);
                    default: rsp_ready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    // ---------------------------------------------------------------
    // Monitor: check the response first, then predict for the word
    // taken on the same edge (a response never comes out on the edge that takes its word).
    // ---------------------------------------------------------------
    pli_rsp_t want;

    always @(posedge clk) begin
        if (rst_n) begin
            req_took <= req_valid && req_ready;
            if (rsp_valid && rsp_ready) begin
                rsp_seen++;
                if (owed_rsps.size() == 0) begin
                    $display("%0t: response with nothing pending, expected none, actual %p",
                             $time, rsp);
                    fail_count++;
                end
                else begin
                    want = owed_rsps.pop_front();
                    check_field("out_first",   32'(want.out_first),   32'(rsp.out_first));
                    check_field("out_second",  32'(want.out_second),  32'(rsp.out_second));
                    check_field("found",       32'(want.found),       32'(rsp.found));
                    check_field("full_drop",   32'(want.full_drop),   32'(rsp.full_drop));
                    check_field("entry_count", 32'(want.entry_count), 32'(rsp.entry_count));
                end
            end
            if (req_valid && req_ready)
                owed_rsps = {owed_rsps, list_step(req)};
        end
    end

    // Watchdog: too long with no word moving on either side.
    int quiet_cycles = 0;

    always @(posedge clk) begin
        if (rst_n) begin
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("%0t: no progress for %0d cycles", $time, quiet_cycles);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------
    // Stimulus plan and end of run.
    // ---------------------------------------------------------------
    initial begin
        int n;
        int pick;
        int r;

        // Directed: empty list, both rank extremes, front/middle/append.
        queue_lookup(0);
        queue_lookup(MAX_RANK);
        queue_insert(0, 16'hFFFF, 16'hFFFF);
        queue_insert(MAX_RANK, 16'h0000, 16'h0000);     // past the end: append
        queue_insert(0, 16'h5555, 16'hAAAA);            // front, shifts all
        queue_insert(1, 16'hAAAA, 16'h5555);            // middle
        queue_insert(4, 16'h1234, 16'hFEDC);            // rank == count: append
        queue_insert(CAP, 16'h8000, 16'h0001);          // past the end
        for (n = 0; n < 7; n++)
            queue_lookup(n);
        queue_lookup(6);                                // rank == count: miss
        queue_lookup(CAP);
        queue_lookup(MAX_RANK);
        queue_insert(3, 16'h0001, 16'h8000);
        queue_lookup(3);
        queue_lookup(7);

        // Random mix: mostly inserts so the list grows; lookups lean toward
        // low ranks to keep latency down, with misses mixed in.
        for (n = 0; n < RANDOM_WORDS; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 65) begin
                if ($urandom_range(0, 9) == 0)
                    r = $urandom_range(plan_len, MAX_RANK);
                else
                    r = $urandom_range(0, plan_len);
                queue_insert(r, ELEM_FW'($urandom), ELEM_FW'($urandom));
            end
            else if (pick < 88 && plan_len > 0) begin
                if ($urandom_range(0, 1) == 0)
                    r = $urandom_range(0, (plan_len > 16) ? 15 : plan_len - 1);
                else
                    r = $urandom_range(0, plan_len - 1);
                queue_lookup(r);
            end
            else begin
                queue_lookup($urandom_range(plan_len, MAX_RANK));
            end
        end

        // Fill to capacity, then inserts into a full list and far lookups.
        while (plan_len < CAP)
            queue_insert($urandom_range(0, plan_len), ELEM_FW'($urandom), ELEM_FW'($urandom));
        queue_insert(0, 16'hFFFF, 16'hFFFF);
        queue_insert(MAX_RANK, 16'h1111, 16'h2222);
        queue_lookup(CAP - 1);
        queue_lookup(0);
        queue_insert(CAP / 2, ELEM_FW'($urandom), ELEM_FW'($urandom));
        queue_lookup(CAP);
        queue_lookup(MAX_RANK);
        queue_lookup(CAP / 2);
        for (n = 0; n < 16; n++)
            queue_lookup($urandom_range(0, CAP - 1));
        queue_insert($urandom_range(0, MAX_RANK), ELEM_FW'($urandom), ELEM_FW'($urandom));

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (pending_words.size() != 0 || req_valid)
            @(posedge clk);
        while (owed_rsps.size() != 0)
            @(posedge clk);
        // catch any stray response after the last expected one
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
